// ===== rtl/jstc_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and character classifier for the json scalar token classifier
// no dependencies

package jstc_pkg;

    // request queue between the front and back parts
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // result queue at the output
    localparam int OUT_DEPTH = 2;
    localparam int OUT_AW    = $clog2(OUT_DEPTH);

    localparam logic [7:0] CH_MINUS  = "-";
    localparam logic [7:0] CH_PLUS   = "+";
    localparam logic [7:0] CH_DOT    = ".";
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_ZERO   = "0";
    localparam logic [7:0] CH_NINE   = "9";

    localparam logic [31:0] LIT_TRUE  = "true";
    localparam logic [39:0] LIT_FALSE = "false";
    localparam logic [31:0] LIT_NULL  = "null";
    localparam logic [15:0] EXP_MARKS = "eE";

    typedef enum logic [2:0] {
        TYPE_NONE    = 3'd0,
        TYPE_INTEGER = 3'd1,
        TYPE_REAL    = 3'd2,
        TYPE_STRING  = 3'd3,
        TYPE_TRUE    = 3'd4,
        TYPE_FALSE   = 3'd5,
        TYPE_NULL    = 3'd6
    } t_type_code;

    typedef enum logic [3:0] {
        PH_START   = 4'd0,
        PH_MINUS   = 4'd1,
        PH_INT     = 4'd2,
        PH_DOT     = 4'd3,
        PH_FRAC    = 4'd4,
        PH_EXP     = 4'd5,
        PH_EXPSIGN = 4'd6,
        PH_EXPDIG  = 4'd7
    } t_num_phase;

    // one classified character as the back part sees it
    typedef struct packed {
        logic       digit;
        logic       minus;
        logic       plus;
        logic       dot;
        logic       expm;
        logic       quote;
        logic       bslash;
        logic [2:0] lit_hit;   // bit 0 true, bit 1 false, bit 2 null
        logic       first;     // first character of the token
        logic       len4;      // fourth character
        logic       len5;      // fifth character
        logic       last;
    } t_char_info;

    // which literals expect this character at this position
    function automatic logic [2:0] lit_hits(logic [2:0] pos, logic [7:0] c);
        logic [2:0] hit;
        hit = '0;
        case (pos)
            3'd0: begin
                hit[0] = (c == LIT_TRUE[31:24]);
                hit[1] = (c == LIT_FALSE[39:32]);
                hit[2] = (c == LIT_NULL[31:24]);
            end
            3'd1: begin
                hit[0] = (c == LIT_TRUE[23:16]);
                hit[1] = (c == LIT_FALSE[31:24]);
                hit[2] = (c == LIT_NULL[23:16]);
            end
            3'd2: begin
                hit[0] = (c == LIT_TRUE[15:8]);
                hit[1] = (c == LIT_FALSE[23:16]);
                hit[2] = (c == LIT_NULL[15:8]);
            end
            3'd3: begin
                hit[0] = (c == LIT_TRUE[7:0]);
                hit[1] = (c == LIT_FALSE[15:8]);
                hit[2] = (c == LIT_NULL[7:0]);
            end
            3'd4: begin
                hit[1] = (c == LIT_FALSE[7:0]);
            end
            default: begin
                hit = '0;
            end
        endcase
        return hit;
    endfunction

    function automatic t_char_info classify(logic [7:0] c, logic [2:0] pos, logic last);
        t_char_info info;
        info.digit   = (c >= CH_ZERO) && (c <= CH_NINE);
        info.minus   = (c == CH_MINUS);
        info.plus    = (c == CH_PLUS);
        info.dot     = (c == CH_DOT);
        info.expm    = (c == EXP_MARKS[15:8]) || (c == EXP_MARKS[7:0]);
        info.quote   = (c == CH_QUOTE);
        info.bslash  = (c == CH_BSLASH);
        info.lit_hit = lit_hits(pos, c);
        info.first   = (pos == 3'd0);
        info.len4    = (pos == 3'd3);
        info.len5    = (pos == 3'd4);
        info.last    = last;
        return info;
    endfunction

endpackage

// ===== rtl/jstc_front.sv =====
`timescale 1ns / 1ps
// front part: takes characters, tracks position in the token, classifies each one
// depends on jstc_pkg

module jstc_front import jstc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [7:0] i_char_code,
    input  logic       i_is_last,
    input  logic       i_q_full,
    output logic       o_full,
    output logic       o_q_push,
    output t_char_info o_q_data
);

    logic [2:0] r_pos;
    logic [2:0] n_pos;
    logic       accept;

    assign accept   = i_push & ~i_q_full;
    assign o_full   = i_q_full;
    assign o_q_push = accept;
    assign o_q_data = classify(i_char_code, r_pos, i_is_last);

    // position saturates at seven, restarts after the last character
    always_comb begin
        n_pos = r_pos;
        if (accept) begin
            if (i_is_last) begin
                n_pos = 3'd0;
            end else if (r_pos != 3'd7) begin
                n_pos = r_pos + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 3'd0;
        end else begin
            r_pos <= n_pos;
        end
    end

endmodule

// ===== rtl/jstc_queue.sv =====
`timescale 1ns / 1ps
// short request queue between front and back parts
// depends on jstc_pkg

module jstc_queue import jstc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_char_info i_data,
    output logic       o_full,
    input  logic       i_pop,
    output t_char_info o_data,
    output logic       o_empty
);

    localparam logic [QUEUE_AW:0]   CNT_FULL = (QUEUE_AW+1)'(QUEUE_DEPTH);
    localparam logic [QUEUE_AW:0]   CNT_ONE  = (QUEUE_AW+1)'(1);
    localparam logic [QUEUE_AW-1:0] PTR_LAST = QUEUE_AW'(QUEUE_DEPTH - 1);
    localparam logic [QUEUE_AW-1:0] PTR_ONE  = QUEUE_AW'(1);

    t_char_info          r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr;
    logic [QUEUE_AW-1:0] r_rd;
    logic [QUEUE_AW:0]   r_cnt;
    logic                wr_en;
    logic                rd_en;

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_empty = (r_cnt == '0);
    assign wr_en   = i_push & ~o_full;
    assign rd_en   = i_pop & ~o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + PTR_ONE;
            end
            if (rd_en) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + PTR_ONE;
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + CNT_ONE;
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - CNT_ONE;
            end
        end
    end

endmodule

// ===== rtl/jstc_back.sv =====
`timescale 1ns / 1ps
// back part: number, string and literal grammars, result code and result queue
// depends on jstc_pkg

module jstc_back import jstc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_empty,
    input  t_char_info i_q_data,
    output logic       o_q_pop,
    input  logic       i_pop,
    output logic       o_empty,
    output t_type_code o_type_code
);

    localparam logic [OUT_AW:0]   OCNT_FULL = (OUT_AW+1)'(OUT_DEPTH);
    localparam logic [OUT_AW:0]   OCNT_ONE  = (OUT_AW+1)'(1);
    localparam logic [OUT_AW-1:0] OPTR_LAST = OUT_AW'(OUT_DEPTH - 1);

    t_num_phase r_phase, n_phase;
    logic       r_num_alive, n_num_alive;
    logic       r_str_alive, n_str_alive;
    logic       r_prev_bs, n_prev_bs;
    logic [2:0] r_lit, n_lit;

    t_type_code        r_out_data [OUT_DEPTH];
    logic [OUT_AW-1:0] r_out_wr;
    logic [OUT_AW-1:0] r_out_rd;
    logic [OUT_AW:0]   r_out_cnt;

    t_char_info it;
    t_num_phase ph_step;
    logic       num_ok;
    logic       take;
    logic       out_push;
    logic       out_pop;
    logic       alive_after;
    t_num_phase phase_after;
    logic       str_after;
    logic [2:0] lit_after;
    t_type_code code;

    assign it       = i_q_data;
    // a last character needs room in the result queue
    assign take     = ~i_q_empty & (~it.last | (r_out_cnt != OCNT_FULL));
    assign o_q_pop  = take;
    assign out_push = take & it.last;
    assign out_pop  = i_pop & ~o_empty;

    // number grammar step
    always_comb begin
        ph_step = r_phase;
        num_ok  = 1'b0;
        unique case (r_phase)
            PH_START: begin
                if (it.minus) begin
                    ph_step = PH_MINUS;
                    num_ok  = 1'b1;
                end else if (it.digit) begin
                    ph_step = PH_INT;
                    num_ok  = 1'b1;
                end
            end
            PH_MINUS: begin
                if (it.digit) begin
                    ph_step = PH_INT;
                    num_ok  = 1'b1;
                end
            end
            PH_INT: begin
                if (it.digit) begin
                    ph_step = PH_INT;
                    num_ok  = 1'b1;
                end else if (it.dot) begin
                    ph_step = PH_DOT;
                    num_ok  = 1'b1;
                end else if (it.expm) begin
                    ph_step = PH_EXP;
                    num_ok  = 1'b1;
                end
            end
            PH_DOT: begin
                if (it.digit) begin
                    ph_step = PH_FRAC;
                    num_ok  = 1'b1;
                end
            end
            PH_FRAC: begin
                if (it.digit) begin
                    ph_step = PH_FRAC;
                    num_ok  = 1'b1;
                end else if (it.expm) begin
                    ph_step = PH_EXP;
                    num_ok  = 1'b1;
                end
            end
            PH_EXP: begin
                if (it.plus || it.minus) begin
                    ph_step = PH_EXPSIGN;
                    num_ok  = 1'b1;
                end else if (it.digit) begin
                    ph_step = PH_EXPDIG;
                    num_ok  = 1'b1;
                end
            end
            PH_EXPSIGN, PH_EXPDIG: begin
                if (it.digit) begin
                    ph_step = PH_EXPDIG;
                    num_ok  = 1'b1;
                end
            end
            default: begin
                num_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        alive_after = r_num_alive & num_ok;
        phase_after = alive_after ? ph_step : r_phase;
        // inner quote must follow a backslash, first character must be a quote
        if (it.first) begin
            str_after = r_str_alive & it.quote;
        end else begin
            str_after = r_str_alive & ~(it.quote & ~it.last & ~r_prev_bs);
        end
        lit_after = r_lit & it.lit_hit;

        if (alive_after && phase_after == PH_INT) begin
            code = TYPE_INTEGER;
        end else if (alive_after && (phase_after == PH_FRAC || phase_after == PH_EXPDIG)) begin
            code = TYPE_REAL;
        end else if (str_after && !it.first && it.quote) begin
            code = TYPE_STRING;
        end else if (lit_after[0] && it.len4) begin
            code = TYPE_TRUE;
        end else if (lit_after[1] && it.len5) begin
            code = TYPE_FALSE;
        end else if (lit_after[2] && it.len4) begin
            code = TYPE_NULL;
        end else begin
            code = TYPE_NONE;
        end
    end

    // token state, back to start after the last character
    always_comb begin
        n_phase     = r_phase;
        n_num_alive = r_num_alive;
        n_str_alive = r_str_alive;
        n_prev_bs   = r_prev_bs;
        n_lit       = r_lit;
        if (take) begin
            if (it.last) begin
                n_phase     = PH_START;
                n_num_alive = 1'b1;
                n_str_alive = 1'b1;
                n_prev_bs   = 1'b0;
                n_lit       = 3'b111;
            end else begin
                n_phase     = phase_after;
                n_num_alive = alive_after;
                n_str_alive = str_after;
                n_prev_bs   = it.bslash;
                n_lit       = lit_after;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_num_alive <= 1'b1;
            r_str_alive <= 1'b1;
            r_prev_bs   <= 1'b0;
            r_lit       <= 3'b111;
        end else begin
            r_phase     <= n_phase;
            r_num_alive <= n_num_alive;
            r_str_alive <= n_str_alive;
            r_prev_bs   <= n_prev_bs;
            r_lit       <= n_lit;
        end
    end

    // result queue
    assign o_empty     = (r_out_cnt == '0);
    assign o_type_code = r_out_data[r_out_rd];

    always_ff @(posedge i_clk) begin
        if (out_push) begin
            r_out_data[r_out_wr] <= code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_wr  <= '0;
            r_out_rd  <= '0;
            r_out_cnt <= '0;
        end else begin
            if (out_push) begin
                r_out_wr <= (r_out_wr == OPTR_LAST) ? '0 : r_out_wr + 1'b1;
            end
            if (out_pop) begin
                r_out_rd <= (r_out_rd == OPTR_LAST) ? '0 : r_out_rd + 1'b1;
            end
            if (out_push && !out_pop) begin
                r_out_cnt <= r_out_cnt + OCNT_ONE;
            end else if (out_pop && !out_push) begin
                r_out_cnt <= r_out_cnt - OCNT_ONE;
            end
        end
    end

endmodule

// ===== rtl/json_scalar_token_classifier.sv =====
`timescale 1ns / 1ps
// top level of the json scalar token classifier: front, request queue, back
// depends on jstc_pkg, jstc_front, jstc_queue, jstc_back
//
//  channel  | handshake        | payload                    | direction
//  ---------+------------------+----------------------------+----------
//  input    | push / full      | i_char_code[7:0] i_is_last | in
//  result   | empty / pop      | o_type_code[2:0]           | out
//
// one character per cycle while full is low; the front classifies and queues each
// request; the back updates token grammars one character per cycle unless stalled
// a result is written into the result queue when the back takes the last character
// the result queue holds two results; with it full the back stalls on a last
// character, the request queue fills, and full rises within three more characters
// reset is synchronous, active low, clears all queues and the token state

module json_scalar_token_classifier import jstc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_char_code,
    input  logic       i_is_last,
    output logic       empty,
    input  logic       pop,
    output logic [2:0] o_type_code
);

    // front to queue
    logic       q_push;
    logic       q_full;
    t_char_info q_wdata;
    // queue to back
    logic       q_pop;
    logic       q_empty;
    t_char_info q_rdata;
    t_type_code type_code;

    // front: position tracking and per character classification
    jstc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_char_code (i_char_code),
        .i_is_last   (i_is_last),
        .i_q_full    (q_full),
        .o_full      (full),
        .o_q_push    (q_push),
        .o_q_data    (q_wdata)
    );

    // decouples the front from stalls on the result side
    jstc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    // back: grammar state, final decision, result queue
    jstc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_data    (q_rdata),
        .o_q_pop     (q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_type_code (type_code)
    );

    assign o_type_code = type_code;

endmodule

// ===== rtl/jstc_checker.sv =====
`timescale 1ns / 1ps
// port level checks for the json scalar token classifier, bound to the top level
// depends on jstc_pkg and json_scalar_token_classifier

module jstc_checker import jstc_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       push,
    input logic       full,
    input logic       i_is_last,
    input logic       empty,
    input logic       pop,
    input logic [2:0] o_type_code
);

    // tokens whose last character went in and whose result is not yet taken
    logic [3:0] r_pending;
    logic       last_in;
    logic       res_out;

    assign last_in = push & ~full & i_is_last;
    assign res_out = pop & ~empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (last_in && !res_out) begin
            r_pending <= r_pending + 4'd1;
        end else if (res_out && !last_in) begin
            r_pending <= r_pending - 4'd1;
        end
    end

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    a_no_invented_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> r_pending != 4'd0)
        else $error("result without a finished token");

    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_type_code != 3'd7)
        else $error("type code out of range");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(!empty && !pop) |-> !empty && $stable(o_type_code))
        else $error("waiting result changed");

endmodule

bind json_scalar_token_classifier jstc_checker u_jstc_checker (.*);
